// ===== design/rmq_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the rotation matrix to quaternion block.
// ---------------------------------------------------------------------------
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Which Shepperd branch produced the result.
    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

endpackage
// ---------------------------------------------------------------------------
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Fixed-point rotation matrix to quaternion conversion, Shepperd trace method.
// ---------------------------------------------------------------------------
// This block takes one 3x3 rotation matrix word per cycle and returns one
// quaternion word per cycle, in order, whenever the output is not stalled. It
// is a fully pipelined datapath: a front stage picks the branch and forms the
// root argument, a square-root pipeline produces one root bit per stage, three
// parallel dividers produce one quotient bit per stage, and a final stage
// saturates and registers the result, in the default Q2.14 format. The whole
// pipeline advances together whenever the output register is empty or being
// drained, so in_ready is high unless a finished word is stalled at the
// output. The block holds no state between words and needs no warm-up.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] e00,
    input  wire logic signed [DATA_WIDTH-1:0] e01,
    input  wire logic signed [DATA_WIDTH-1:0] e02,
    input  wire logic signed [DATA_WIDTH-1:0] e10,
    input  wire logic signed [DATA_WIDTH-1:0] e11,
    input  wire logic signed [DATA_WIDTH-1:0] e12,
    input  wire logic signed [DATA_WIDTH-1:0] e20,
    input  wire logic signed [DATA_WIDTH-1:0] e21,
    input  wire logic signed [DATA_WIDTH-1:0] e22,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0]      quat_w,
    output logic signed [DATA_WIDTH-1:0]      quat_x,
    output logic signed [DATA_WIDTH-1:0]      quat_y,
    output logic signed [DATA_WIDTH-1:0]      quat_z,
    output logic [1:0]                        branch_taken,
    output logic                              degenerate
);

    // The root argument must hold one plus three diagonal terms with sign.
    localparam int ARG_W = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
    // The radicand is the positive argument scaled up by the fraction bits.
    localparam int RAD_W = ARG_W - 1 + FRAC_BITS;
    localparam int SQ_W  = (RAD_W + 1) / 2;
    localparam int NW    = DATA_WIDTH + 1;
    // Quotient wide enough for the scaled numerator plus the rounding bias.
    localparam int QW    = ((NW + FRAC_BITS > SQ_W) ? NW + FRAC_BITS : SQ_W) + 1;
    localparam int SB_W  = 3 + 3 * NW;

    logic                 en;

    logic                 f_valid, f_degen;
    branch_t              f_br;
    logic [2*SQ_W-1:0]    f_rad;
    logic signed [NW-1:0] f_n0, f_n1, f_n2;

    logic                 s_valid;
    logic [SQ_W-1:0]      s_root;
    logic [SB_W-1:0]      s_sb_in, s_sb_out;

    logic                 d_valid, d_degen;
    logic [QW-1:0]        d_q0, d_q1, d_q2;
    logic [2:0]           d_neg;
    logic [SQ_W-1:0]      d_root;
    branch_t              d_br;

    // One shared enable: every stage moves when the output slot frees up.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    rmq_front #(
        .DW    (DATA_WIDTH),
        .FB    (FRAC_BITS),
        .ARG_W (ARG_W),
        .SQ_W  (SQ_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .e00       (e00),
        .e01       (e01),
        .e02       (e02),
        .e10       (e10),
        .e11       (e11),
        .e12       (e12),
        .e20       (e20),
        .e21       (e21),
        .e22       (e22),
        .out_valid (f_valid),
        .br        (f_br),
        .degen     (f_degen),
        .rad       (f_rad),
        .n0        (f_n0),
        .n1        (f_n1),
        .n2        (f_n2)
    );

    // Branch, degenerate flag and numerators ride alongside the root pipeline.
    assign s_sb_in = {2'(f_br), f_degen, f_n0, f_n1, f_n2};

    rmq_sqrt #(
        .SQ_W (SQ_W),
        .SB_W (SB_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .rad_in    (f_rad),
        .sb_in     (s_sb_in),
        .out_valid (s_valid),
        .root      (s_root),
        .sb_out    (s_sb_out)
    );

    rmq_div #(
        .DW   (DATA_WIDTH),
        .FB   (FRAC_BITS),
        .SQ_W (SQ_W),
        .QW   (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .root_in   (s_root),
        .br_in     (branch_t'(s_sb_out[SB_W-1 -: 2])),
        .degen_in  (s_sb_out[SB_W-3]),
        .n0        (s_sb_out[3*NW-1 -: NW]),
        .n1        (s_sb_out[2*NW-1 -: NW]),
        .n2        (s_sb_out[NW-1:0]),
        .out_valid (d_valid),
        .q0        (d_q0),
        .q1        (d_q1),
        .q2        (d_q2),
        .neg       (d_neg),
        .root_out  (d_root),
        .br_out    (d_br),
        .degen_out (d_degen)
    );

    rmq_out #(
        .DW   (DATA_WIDTH),
        .SQ_W (SQ_W),
        .QW   (QW)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (d_valid),
        .q0           (d_q0),
        .q1           (d_q1),
        .q2           (d_q2),
        .neg          (d_neg),
        .root         (d_root),
        .br           (d_br),
        .degen        (d_degen),
        .out_valid    (out_valid),
        .quat_w       (quat_w),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .branch_taken (branch_taken),
        .degenerate   (degenerate)
    );

endmodule
// ---------------------------------------------------------------------------
`default_nettype wire

// ===== design/rmq_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rmq_front
// Trace, branch choice, square-root radicand and the three off-axis numerators.
// ---------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
#(
    parameter int DW    = DATA_WIDTH_DEF,
    parameter int FB    = FRAC_BITS_DEF,
    parameter int ARG_W = 19,
    parameter int SQ_W  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [DW-1:0] e00,
    input  wire logic signed [DW-1:0] e01,
    input  wire logic signed [DW-1:0] e02,
    input  wire logic signed [DW-1:0] e10,
    input  wire logic signed [DW-1:0] e11,
    input  wire logic signed [DW-1:0] e12,
    input  wire logic signed [DW-1:0] e20,
    input  wire logic signed [DW-1:0] e21,
    input  wire logic signed [DW-1:0] e22,
    output logic                      out_valid,
    output branch_t                   br,
    output logic                      degen,
    output logic [2*SQ_W-1:0]         rad,
    output logic signed [DW:0]        n0,
    output logic signed [DW:0]        n1,
    output logic signed [DW:0]        n2
);

    localparam int NW = DW + 1;

    logic signed [ARG_W-1:0] a00, a11, a22, trace, one_v, arg;
    logic signed [NW-1:0]    d_x, d_y, d_z, s_xy, s_xz, s_yz;
    logic [ARG_W-2:0]        arg_pos;

    logic                    valid_reg;
    branch_t                 br_reg, br_next;
    logic                    degen_reg, degen_next;
    logic [2*SQ_W-1:0]       rad_reg, rad_next;
    logic signed [NW-1:0]    n0_reg, n1_reg, n2_reg, n0_next, n1_next, n2_next;

    assign a00   = ARG_W'(e00);
    assign a11   = ARG_W'(e11);
    assign a22   = ARG_W'(e22);
    assign trace = a00 + a11 + a22;
    assign one_v = ARG_W'(1) << FB;

    assign d_x  = NW'(e21) - NW'(e12);
    assign d_y  = NW'(e02) - NW'(e20);
    assign d_z  = NW'(e10) - NW'(e01);
    assign s_xy = NW'(e01) + NW'(e10);
    assign s_xz = NW'(e02) + NW'(e20);
    assign s_yz = NW'(e12) + NW'(e21);

    always_comb
    begin
        priority if (trace > 0)
        begin
            br_next = BR_TRACE;
            arg     = trace + one_v;
            n0_next = d_x;
            n1_next = d_y;
            n2_next = d_z;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            br_next = BR_X;
            arg     = one_v + a00 - a11 - a22;
            n0_next = d_x;
            n1_next = s_xy;
            n2_next = s_xz;
        end
        else if (a11 > a22)
        begin
            br_next = BR_Y;
            arg     = one_v + a11 - a00 - a22;
            n0_next = d_y;
            n1_next = s_xy;
            n2_next = s_yz;
        end
        else
        begin
            br_next = BR_Z;
            arg     = one_v + a22 - a00 - a11;
            n0_next = d_z;
            n1_next = s_xz;
            n2_next = s_yz;
        end
        degen_next = (arg <= 0);
        // A degenerate word still flows through the root unit; feed it a harmless value.
        arg_pos  = degen_next ? (ARG_W-1)'(1) : arg[ARG_W-2:0];
        rad_next = (2*SQ_W)'(arg_pos) << FB;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            br_reg    <= br_next;
            degen_reg <= degen_next;
            rad_reg   <= rad_next;
            n0_reg    <= n0_next;
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
        end
    end

    assign out_valid = valid_reg;
    assign br        = br_reg;
    assign degen     = degen_reg;
    assign rad       = rad_reg;
    assign n0        = n0_reg;
    assign n1        = n1_reg;
    assign n2        = n2_reg;

endmodule
// ---------------------------------------------------------------------------
`default_nettype wire

// ===== design/rmq_sqrt.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage, with a side channel.
// ---------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int SQ_W = 16,
    parameter int SB_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [2*SQ_W-1:0] rad_in,
    input  wire logic [SB_W-1:0]   sb_in,
    output logic                   out_valid,
    output logic [SQ_W-1:0]        root,
    output logic [SB_W-1:0]        sb_out
);

    localparam int REM_W = SQ_W + 3;

    logic              valid_reg [SQ_W];
    logic [2*SQ_W-1:0] rad_reg   [SQ_W];
    logic [REM_W-1:0]  rem_reg   [SQ_W];
    logic [SQ_W-1:0]   root_reg  [SQ_W];
    logic [SB_W-1:0]   sb_reg    [SQ_W];

    logic [2*SQ_W-1:0] rad_s  [SQ_W];
    logic [REM_W-1:0]  rem_s  [SQ_W];
    logic [SQ_W-1:0]   root_s [SQ_W];
    logic [REM_W-1:0]  rem_sh [SQ_W];
    logic [REM_W-1:0]  trial  [SQ_W];
    logic [2*SQ_W-1:0] rad_next  [SQ_W];
    logic [REM_W-1:0]  rem_next  [SQ_W];
    logic [SQ_W-1:0]   root_next [SQ_W];

    always_comb
    begin
        for (int k = 0; k < SQ_W; k++)
        begin
            if (k == 0)
            begin
                rad_s[k]  = rad_in;
                rem_s[k]  = '0;
                root_s[k] = '0;
            end
            else
            begin
                rad_s[k]  = rad_reg[k-1];
                rem_s[k]  = rem_reg[k-1];
                root_s[k] = root_reg[k-1];
            end
            rem_sh[k]   = {rem_s[k][REM_W-3:0], rad_s[k][2*SQ_W-1 -: 2]};
            trial[k]    = REM_W'({root_s[k], 2'b01});
            rad_next[k] = rad_s[k] << 2;
            if (rem_sh[k] >= trial[k])
            begin
                rem_next[k]  = rem_sh[k] - trial[k];
                root_next[k] = {root_s[k][SQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh[k];
                root_next[k] = {root_s[k][SQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < SQ_W; k++)
            begin
                valid_reg[k] <= (k == 0) ? in_valid : valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_W; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                sb_reg[k]   <= (k == 0) ? sb_in : sb_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[SQ_W-1];
    assign root      = root_reg[SQ_W-1];
    assign sb_out    = sb_reg[SQ_W-1];

endmodule
// ---------------------------------------------------------------------------
`default_nettype wire

// ===== design/rmq_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rmq_div
// Three pipelined restoring dividers computing round(|N| / 2R), one bit a stage.
// ---------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
#(
    parameter int DW   = DATA_WIDTH_DEF,
    parameter int FB   = FRAC_BITS_DEF,
    parameter int SQ_W = 16,
    parameter int QW   = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [SQ_W-1:0]   root_in,
    input  wire branch_t           br_in,
    input  wire logic              degen_in,
    input  wire logic signed [DW:0] n0,
    input  wire logic signed [DW:0] n1,
    input  wire logic signed [DW:0] n2,
    output logic                   out_valid,
    output logic [QW-1:0]          q0,
    output logic [QW-1:0]          q1,
    output logic [QW-1:0]          q2,
    output logic [2:0]             neg,
    output logic [SQ_W-1:0]        root_out,
    output branch_t                br_out,
    output logic                   degen_out
);

    localparam int NW    = DW + 1;
    localparam int NS    = QW + 1;
    localparam int DVS_W = SQ_W + 1;
    localparam int REM_W = DVS_W + 1;

    logic              valid_reg [NS];
    logic [QW-1:0]     dvd_reg   [NS][3];
    logic [DVS_W-1:0]  rem_reg   [NS][3];
    logic [2:0]        neg_reg   [NS];
    logic [SQ_W-1:0]   root_reg  [NS];
    branch_t           br_reg    [NS];
    logic              degen_reg [NS];

    logic signed [NW-1:0] n_in [3];
    logic [NW-1:0]     mag    [3];
    logic [QW-1:0]     dvd_next [NS][3];
    logic [DVS_W-1:0]  rem_next [NS][3];
    logic [REM_W-1:0]  rem_sh   [NS][3];
    logic [REM_W-1:0]  dvs      [NS];

    assign n_in[0] = n0;
    assign n_in[1] = n1;
    assign n_in[2] = n2;

    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            dvs[s] = (s == 0) ? REM_W'({root_in, 1'b0}) : REM_W'({root_reg[s-1], 1'b0});
            for (int l = 0; l < 3; l++)
            begin
                if (s == 0)
                begin
                    // Rounding bias R added to the scaled magnitude.
                    mag[l]         = n_in[l][NW-1] ? NW'(-n_in[l]) : NW'(n_in[l]);
                    rem_sh[s][l]   = '0;
                    dvd_next[s][l] = QW'({mag[l], {FB{1'b0}}}) + QW'(root_in);
                    rem_next[s][l] = '0;
                end
                else
                begin
                    rem_sh[s][l] = {rem_reg[s-1][l], dvd_reg[s-1][l][QW-1]};
                    if (rem_sh[s][l] >= dvs[s])
                    begin
                        rem_next[s][l] = DVS_W'(rem_sh[s][l] - dvs[s]);
                        dvd_next[s][l] = {dvd_reg[s-1][l][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[s][l] = DVS_W'(rem_sh[s][l]);
                        dvd_next[s][l] = {dvd_reg[s-1][l][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    dvd_reg[s][l] <= dvd_next[s][l];
                    rem_reg[s][l] <= rem_next[s][l];
                end
                if (s == 0)
                begin
                    neg_reg[s]   <= {n2[NW-1], n1[NW-1], n0[NW-1]};
                    root_reg[s]  <= root_in;
                    br_reg[s]    <= br_in;
                    degen_reg[s] <= degen_in;
                end
                else
                begin
                    neg_reg[s]   <= neg_reg[s-1];
                    root_reg[s]  <= root_reg[s-1];
                    br_reg[s]    <= br_reg[s-1];
                    degen_reg[s] <= degen_reg[s-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign q0        = dvd_reg[NS-1][0];
    assign q1        = dvd_reg[NS-1][1];
    assign q2        = dvd_reg[NS-1][2];
    assign neg       = neg_reg[NS-1];
    assign root_out  = root_reg[NS-1];
    assign br_out    = br_reg[NS-1];
    assign degen_out = degen_reg[NS-1];

endmodule
// ---------------------------------------------------------------------------
`default_nettype wire

// ===== design/rmq_out.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rmq_out
// Sign, saturation, component placement and the output register.
// ---------------------------------------------------------------------------
module rmq_out
    import rmq_pkg::*;
#(
    parameter int DW   = DATA_WIDTH_DEF,
    parameter int SQ_W = 16,
    parameter int QW   = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [QW-1:0]     q0,
    input  wire logic [QW-1:0]     q1,
    input  wire logic [QW-1:0]     q2,
    input  wire logic [2:0]        neg,
    input  wire logic [SQ_W-1:0]   root,
    input  wire branch_t           br,
    input  wire logic              degen,
    output logic                   out_valid,
    output logic signed [DW-1:0]   quat_w,
    output logic signed [DW-1:0]   quat_x,
    output logic signed [DW-1:0]   quat_y,
    output logic signed [DW-1:0]   quat_z,
    output logic [1:0]             branch_taken,
    output logic                   degenerate
);

    localparam logic [QW-1:0] NEG_LIM = QW'(1) << (DW - 1);
    localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

    function automatic logic [DW-1:0] sat_mag(input logic [QW-1:0] m, input logic ng);
        logic [DW-1:0] res;
        if (ng)
        begin
            res = (m > NEG_LIM) ? NEG_LIM[DW-1:0] : DW'(-m[DW-1:0]);
        end
        else
        begin
            res = (m > POS_LIM) ? POS_LIM[DW-1:0] : m[DW-1:0];
        end
        return res;
    endfunction

    logic [SQ_W:0]   dom_sum;
    logic [DW-1:0]   c_dom, c0, c1, c2;
    logic [DW-1:0]   w_next, x_next, y_next, z_next;

    logic            valid_reg;
    logic [DW-1:0]   w_reg, x_reg, y_reg, z_reg;
    logic [1:0]      br_reg;
    logic            degen_reg;

    always_comb
    begin
        dom_sum = (SQ_W+1)'(root) + (SQ_W+1)'(1);
        c_dom   = sat_mag(QW'(dom_sum >> 1), 1'b0);
        c0      = sat_mag(q0, neg[0]);
        c1      = sat_mag(q1, neg[1]);
        c2      = sat_mag(q2, neg[2]);
        unique case (br)
            BR_TRACE:
            begin
                w_next = c_dom; x_next = c0;    y_next = c1;    z_next = c2;
            end
            BR_X:
            begin
                w_next = c0;    x_next = c_dom; y_next = c1;    z_next = c2;
            end
            BR_Y:
            begin
                w_next = c0;    x_next = c1;    y_next = c_dom; z_next = c2;
            end
            default:
            begin
                w_next = c0;    x_next = c1;    y_next = c2;    z_next = c_dom;
            end
        endcase
        if (degen)
        begin
            w_next = '0;
            x_next = '0;
            y_next = '0;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= w_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            br_reg    <= 2'(br);
            degen_reg <= degen;
        end
    end

    assign out_valid    = valid_reg;
    assign quat_w       = w_reg;
    assign quat_x       = x_reg;
    assign quat_y       = y_reg;
    assign quat_z       = z_reg;
    assign branch_taken = br_reg;
    assign degenerate   = degen_reg;

endmodule
// ---------------------------------------------------------------------------
`default_nettype wire

// ===== design/rmq_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion block.
// ---------------------------------------------------------------------------
module rmq_checker
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [DATA_WIDTH-1:0] quat_w,
    input wire logic [DATA_WIDTH-1:0] quat_x,
    input wire logic [DATA_WIDTH-1:0] quat_y,
    input wire logic [DATA_WIDTH-1:0] quat_z,
    input wire logic [1:0]            branch_taken,
    input wire logic                  degenerate
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
            && $stable(quat_y) && $stable(quat_z) && $stable(branch_taken)
            && $stable(degenerate))
        else $error("result word changed while stalled");

    // The input side only waits when a finished word is blocked at the output.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled without output back-pressure");

    // A degenerate word carries an all-zero quaternion.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> quat_w == '0 && quat_x == '0
            && quat_y == '0 && quat_z == '0)
        else $error("degenerate word with nonzero components");

    // Positive trace always yields a positive scalar part.
    a_trace_w: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate && branch_taken == 2'(BR_TRACE)
            |-> !quat_w[DATA_WIDTH-1] && quat_w != '0)
        else $error("trace branch produced a non-positive scalar part");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .quat_w       (quat_w),
    .quat_x       (quat_x),
    .quat_y       (quat_y),
    .quat_z       (quat_z),
    .branch_taken (branch_taken),
    .degenerate   (degenerate)
);
// ---------------------------------------------------------------------------
`default_nettype wire

// ===== tb/rotation_matrix_to_quaternion_test.sv =====
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Self-checking bench for the fixed-point matrix to quaternion converter.
// ---------------------------------------------------------------------------
// A short table of hand-picked matrices comes first: the identity, the three
// axis-dominant diagonals, the zero matrix, saturating off-diagonal terms,
// full-scale entries, diagonal ties and axis turns. Random matrices follow,
// nearly half of them noisy signed permutations so that every branch is taken
// with realistic roots, the rest fully random bit patterns and diagonal-biased
// ones. Every accepted word is checked in order, field by field, as it leaves
// the block, against its typed-in result or the local quaternion predictor.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
    import rmq_pkg::*;

    localparam int DW      = DATA_WIDTH_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int ONE     = 1 << FB;
    localparam int N_RAND  = 1130;
    localparam int LATENCY = 51;

    typedef logic signed [DW-1:0] ent_t;
    typedef ent_t mat_t [9];

    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        branch_t              br;
        logic                 degen;
    } quat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ent_t e00 = '0, e01 = '0, e02 = '0, e10 = '0, e11 = '0;
    ent_t e12 = '0, e20 = '0, e21 = '0, e22 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ent_t quat_w, quat_x, quat_y, quat_z;
    logic [1:0] branch_taken;
    logic degenerate;

    // Expected quaternions, oldest first, and run bookkeeping.
    quat_t pending_quats [$];
    int    errors = 0;
    int    words_checked = 0;
    int    branch_seen [4] = '{0, 0, 0, 0};
    bit    quiet = 1'b0;     // set for the last stretch: no idling on either side
    bit    hold_req = 1'b0;  // asks the receiver for one long stall

    rotation_matrix_to_quaternion uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .e00(e00), .e01(e01), .e02(e02),
        .e10(e10), .e11(e11), .e12(e12),
        .e20(e20), .e21(e21), .e22(e22),
        .out_valid(out_valid), .out_ready(out_ready),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .branch_taken(branch_taken), .degenerate(degenerate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Integer square root, bit by bit, exact for any 64-bit operand.
    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Quotient n / (2r) rounded to nearest, halves away from zero.
    function automatic longint half_quotient(longint n, longint unsigned r);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        q = ((mag << FB) + r) / (2 * r);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic ent_t clamp_q(longint v);
        longint hi;
        hi = (longint'(1) << (DW - 1)) - 1;
        if (v > hi)
            return ent_t'(hi);
        if (v < -hi - 1)
            return ent_t'(-hi - 1);
        return ent_t'(v);
    endfunction

    // Shepperd conversion: pick the branch, take the root of its argument,
    // then divide the off-axis numerators by twice the root.
    function automatic quat_t predict_quaternion(mat_t m);
        longint a [9];
        longint tr;
        longint arg;
        longint num [4];
        longint unsigned r;
        ent_t comp [4];
        branch_t br;
        quat_t res;
        for (int i = 0; i < 9; i++)
            a[i] = longint'(m[i]);
        tr = a[0] + a[4] + a[8];
        if (tr > 0)
        begin
            br = BR_TRACE;
            arg = tr + ONE;
        end
        else if (a[0] > a[4] && a[0] > a[8])
        begin
            br = BR_X;
            arg = ONE + a[0] - a[4] - a[8];
        end
        else if (a[4] > a[8])
        begin
            br = BR_Y;
            arg = ONE + a[4] - a[0] - a[8];
        end
        else
        begin
            br = BR_Z;
            arg = ONE + a[8] - a[0] - a[4];
        end
        res = '0;
        res.br = br;
        if (arg <= 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        r = int_root(longint'(arg) << FB);
        // The slot that matches the branch holds the dominant component.
        case (br)
            BR_TRACE: num = '{0, a[7] - a[5], a[2] - a[6], a[3] - a[1]};
            BR_X:     num = '{a[7] - a[5], 0, a[1] + a[3], a[2] + a[6]};
            BR_Y:     num = '{a[2] - a[6], a[1] + a[3], 0, a[5] + a[7]};
            default:  num = '{a[3] - a[1], a[2] + a[6], a[5] + a[7], 0};
        endcase
        for (int i = 0; i < 4; i++)
            comp[i] = (i == int'(br)) ? clamp_q(longint'((r + 1) >> 1))
                                      : clamp_q(half_quotient(num[i], r));
        res.w = comp[0];
        res.x = comp[1];
        res.y = comp[2];
        res.z = comp[3];
        return res;
    endfunction

    function automatic mat_t diag_mat(int d0, int d1, int d2);
        mat_t m;
        m = '{default: '0};
        m[0] = ent_t'(d0);
        m[4] = ent_t'(d1);
        m[8] = ent_t'(d2);
        return m;
    endfunction

    function automatic quat_t quat_of(int w, int x, int y, int z, branch_t br);
        quat_t q;
        q.w = ent_t'(w);
        q.x = ent_t'(x);
        q.y = ent_t'(y);
        q.z = ent_t'(z);
        q.br = br;
        q.degen = 1'b0;
        return q;
    endfunction

    // Random matrix: a noisy signed permutation nearly half the time, otherwise
    // raw bit patterns or a matrix with one forced dominant diagonal entry.
    function automatic mat_t random_matrix();
        mat_t m;
        int mode;
        int p [3];
        int dom;
        int noise;
        mode = $urandom_range(0, 99);
        if (mode < 30)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = ent_t'($urandom);
        end
        else if (mode < 75)
        begin
            noise = 1 << $urandom_range(2, 13);
            p[0] = $urandom_range(0, 2);
            p[1] = (p[0] + 1 + $urandom_range(0, 1)) % 3;
            p[2] = 3 - p[0] - p[1];
            for (int i = 0; i < 9; i++)
                m[i] = ent_t'(int'($urandom_range(0, 2 * noise)) - noise);
            for (int rw = 0; rw < 3; rw++)
                m[3 * rw + p[rw]] = ent_t'(int'(m[3 * rw + p[rw]])
                    + ($urandom_range(0, 1) ? ONE : -ONE));
        end
        else
        begin
            dom = $urandom_range(0, 2);
            for (int i = 0; i < 9; i++)
                m[i] = ent_t'($urandom);
            for (int k = 0; k < 3; k++)
                m[4 * k] = (k == dom) ? ent_t'($urandom_range(0, 32767))
                                      : ent_t'(-int'($urandom_range(0, 32768)));
        end
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH word %0d %s: got %0d, expected %0d",
                 words_checked, what, got, want);
    endtask

    // Output checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_quats.size() == 0)
            begin
                report_mismatch("unexpected result words", 1, 0);
            end
            else
            begin
                quat_t want;
                want = pending_quats.pop_front();
                if (quat_w !== want.w)
                    report_mismatch("quat_w", quat_w, want.w);
                if (quat_x !== want.x)
                    report_mismatch("quat_x", quat_x, want.x);
                if (quat_y !== want.y)
                    report_mismatch("quat_y", quat_y, want.y);
                if (quat_z !== want.z)
                    report_mismatch("quat_z", quat_z, want.z);
                if (branch_taken !== want.br)
                    report_mismatch("branch_taken", branch_taken, want.br);
                if (degenerate !== want.degen)
                    report_mismatch("degenerate", degenerate, want.degen);
                branch_seen[want.br]++;
                words_checked++;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request so that
    // the pipeline fills and in_ready drops, and no stalls once quiet.
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one word and return once it has been taken. A gap, when one is
    // drawn, lowers valid at the edge that accepted the previous word.
    task automatic send_word(mat_t m, quat_t want);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        e00 <= m[0]; e01 <= m[1]; e02 <= m[2];
        e10 <= m[3]; e11 <= m[4]; e12 <= m[5];
        e20 <= m[6]; e21 <= m[7]; e22 <= m[8];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_quats.push_back(want);
    endtask

    // Directed table: matrix, whether the result is typed in, and that result.
    mat_t  dir_mats [$];
    bit    dir_typed [$];
    quat_t dir_quats [$];

    task automatic add_row(mat_t m, bit typed, quat_t q);
        dir_mats.push_back(m);
        dir_typed.push_back(typed);
        dir_quats.push_back(q);
    endtask

    initial
    begin
        mat_t m;
        int cycles;
        // Identity and the three axis-dominant diagonals give exact roots.
        add_row(diag_mat(ONE, ONE, ONE), 1, quat_of(ONE, 0, 0, 0, BR_TRACE));
        add_row(diag_mat(ONE, -ONE, -ONE), 1, quat_of(0, ONE, 0, 0, BR_X));
        add_row(diag_mat(-ONE, ONE, -ONE), 1, quat_of(0, 0, ONE, 0, BR_Y));
        add_row(diag_mat(-ONE, -ONE, ONE), 1, quat_of(0, 0, 0, ONE, BR_Z));
        // The zero matrix ties every diagonal entry and falls to the z branch.
        add_row(diag_mat(0, 0, 0), 1, quat_of(0, 0, 0, ONE / 2, BR_Z));
        // A barely positive trace with a full-scale numerator saturates x high.
        m = diag_mat(0, 0, 1);
        m[7] = 16'sh7fff;
        m[5] = 16'sh8000;
        add_row(m, 1, quat_of(ONE / 2, 32767, 0, 0, BR_TRACE));
        // The mirror case lands exactly on the negative limit.
        m[7] = 16'sh8000;
        m[5] = 16'sh7fff;
        add_row(m, 0, '0);
        m = '{default: 16'sh7fff};
        add_row(m, 0, '0);
        m = '{default: 16'sh8000};
        add_row(m, 0, '0);
        m = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
              16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555};
        add_row(m, 0, '0);
        m = '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
              16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa};
        add_row(m, 0, '0);
        // Diagonal ties with a non-positive trace.
        add_row(diag_mat(-100, -100, -200), 0, '0);
        add_row(diag_mat(-300, -100, -100), 0, '0);
        add_row(diag_mat(-50, -200, -50), 0, '0);
        // Quarter turns about each axis.
        m = '{ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0};
        add_row(m, 0, '0);
        m = '{0, 0, ONE, 0, ONE, 0, -ONE, 0, 0};
        add_row(m, 0, '0);
        m = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};
        add_row(m, 0, '0);
        // Half turn about x: a large trace-negative case with odd offsets.
        m = '{ONE, 3, -7, 5, -ONE, 1, -1, 9, -ONE};
        add_row(m, 0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_mats[i])
            send_word(dir_mats[i], dir_typed[i] ? dir_quats[i]
                                                : predict_quaternion(dir_mats[i]));

        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == 300)
                hold_req = 1'b1;
            if (n == N_RAND - 150)
                quiet = 1'b1;
            m = random_matrix();
            send_word(m, predict_quaternion(m));
        end
        in_valid <= 1'b0;

        cycles = 0;
        while (pending_quats.size() != 0 && cycles < 100000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        if (pending_quats.size() != 0)
            report_mismatch("expected results never arrived", 0,
                            pending_quats.size());
        $display("Converted %0d matrices: %0d directed, %0d random, one long output stall.",
                 words_checked, dir_mats.size(), N_RAND);
        $display("Branches seen: trace %0d, x %0d, y %0d, z %0d; %0d mismatches.",
                 branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3], errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #3000000;
        $display("Timeout: the run did not finish.");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
